FILE: rtl/core/vlgd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlgd_pkg
// Types, group codes and helpers shared by the line group decoder.
// ----------------------------------------------------------------------------
package vlgd_pkg;

	localparam int GroupsPerLineDef = 44;
	localparam int GroupPixels      = 16;

	// group codes
	localparam logic [7:0] CODE_FILL1   = 8'h01;
	localparam logic [7:0] CODE_FILL2   = 8'h02;
	localparam logic [7:0] CODE_BITMAP3 = 8'h03;
	localparam logic [7:0] CODE_FILL4   = 8'h04;
	localparam logic [7:0] CODE_BITMAP6 = 8'h06;
	localparam logic [7:0] CODE_FILL8   = 8'h08;
	localparam logic [7:0] CODE_LITERAL = 8'h10;

	typedef logic [7:0] pixel_t;
	typedef pixel_t [GroupPixels-1:0] group_pix_t;
	typedef pixel_t [1:0] colour_pair_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       line_start;
	} in_item_t;

	typedef struct packed {
		logic [31:0] pixels_0_3;
		logic [31:0] pixels_4_7;
		logic [31:0] pixels_8_11;
		logic [31:0] pixels_12_15;
		logic [5:0]  group_index;
		logic        last_group;
	} out_item_t;

	// control handed to the painter
	typedef struct packed {
		logic       code_byte;   // byte is a group code byte
		logic [7:0] code;        // code in effect for this byte
		logic [3:0] data_idx;    // data byte index within group
	} paint_ctl_t;

	// data bytes that follow a code byte; zero for unknown codes
	function automatic logic [4:0] data_bytes_for(input logic [7:0] code);
		logic [4:0] n;
		case (code)
			CODE_FILL1:   n = 5'd1;
			CODE_FILL2:   n = 5'd2;
			CODE_BITMAP3: n = 5'd3;
			CODE_FILL4:   n = 5'd4;
			CODE_BITMAP6: n = 5'd6;
			CODE_FILL8:   n = 5'd8;
			CODE_LITERAL: n = 5'd16;
			default:      n = 5'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/vlgd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlgd_in_if
// Valid/ready channel carrying compressed line bytes.
// ----------------------------------------------------------------------------
interface vlgd_in_if;
	import vlgd_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/vlgd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlgd_out_if
// Valid/ready channel carrying decoded pixel groups.
// ----------------------------------------------------------------------------
interface vlgd_out_if;
	import vlgd_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/video_line_group_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// video_line_group_decoder_core
// Decodes compressed video lines into 16-pixel groups.
// ----------------------------------------------------------------------------
// Output: a group item appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle, sustained while the output is taken; a byte
// is held off only while a finished group waits in the output register and
// the output side is stalled.
// Reset: arst_n clears the decoder to the code byte of group 0 and empties
// the output register; pixel and colour storage is not reset.
// ----------------------------------------------------------------------------
module video_line_group_decoder_core #(
	parameter int GROUPS_PER_LINE = vlgd_pkg::GroupsPerLineDef
) (
	input  logic            clk,
	input  logic            arst_n,
	vlgd_in_if.sink         in_stream,
	vlgd_out_if.source      out_stream
);
	import vlgd_pkg::*;

	// decoder state
	logic [7:0]   group_code_q;
	logic [4:0]   bytes_taken_q;   // 0: expecting a code byte
	logic [5:0]   group_counter_q;
	group_pix_t   pix_q;
	colour_pair_t col_q;

	// output register
	logic      out_vld_q;
	out_item_t out_item_q;

	logic         take;
	logic [7:0]   b;
	logic [4:0]   bt;          // bytes taken, after line start resync
	logic [5:0]   gc;          // group index, after line start resync
	logic [4:0]   need;
	logic         emit;
	logic         last;
	paint_ctl_t   ctl;
	group_pix_t   pix_nxt;
	colour_pair_t col_nxt;

	// accept whenever the output slot is free or being drained
	assign in_stream.ready = !out_vld_q || out_stream.ready;
	assign take            = in_stream.valid && in_stream.ready;

	assign out_stream.valid = out_vld_q;
	assign out_stream.item  = out_item_q;

	always_comb begin
		b  = in_stream.item.in_byte;
		bt = in_stream.item.line_start ? 5'd0 : bytes_taken_q;
		gc = in_stream.item.line_start ? 6'd0 : group_counter_q;

		ctl.code_byte = (bt == 5'd0);
		ctl.code      = ctl.code_byte ? b : group_code_q;
		ctl.data_idx  = 4'(bt - 5'd1);

		need = data_bytes_for(ctl.code);
		// a code byte of an unknown code completes a black group at once;
		// a data byte completes the group when bt reaches the data count
		emit = ctl.code_byte ? (need == 5'd0) : (bt >= need);
		last = (gc >= 6'(GROUPS_PER_LINE - 1));
	end

	vlgd_painter u_painter (
		.ctl     (ctl),
		.in_byte (b),
		.pix_cur (pix_q),
		.col_cur (col_q),
		.pix_nxt (pix_nxt),
		.col_nxt (col_nxt)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_code_q    <= '0;
			bytes_taken_q   <= '0;
			group_counter_q <= '0;
			out_vld_q       <= 1'b0;
		end else begin
			if (take) begin
				group_code_q <= ctl.code;
				if (emit) begin
					bytes_taken_q   <= 5'd0;
					group_counter_q <= last ? 6'd0 : 6'(gc + 6'd1);
				end else begin
					bytes_taken_q   <= 5'(bt + 5'd1);
					group_counter_q <= gc;
				end
			end
			if (take && emit)
				out_vld_q <= 1'b1;
			else if (out_stream.ready)
				out_vld_q <= 1'b0;
		end
	end

	// pixel storage and result payload
	always_ff @(posedge clk) begin
		if (take) begin
			pix_q <= pix_nxt;
			col_q <= col_nxt;
		end
		if (take && emit) begin
			out_item_q.pixels_0_3   <= {pix_nxt[3],  pix_nxt[2],  pix_nxt[1],  pix_nxt[0]};
			out_item_q.pixels_4_7   <= {pix_nxt[7],  pix_nxt[6],  pix_nxt[5],  pix_nxt[4]};
			out_item_q.pixels_8_11  <= {pix_nxt[11], pix_nxt[10], pix_nxt[9],  pix_nxt[8]};
			out_item_q.pixels_12_15 <= {pix_nxt[15], pix_nxt[14], pix_nxt[13], pix_nxt[12]};
			out_item_q.group_index  <= gc;
			out_item_q.last_group   <= last;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/vlgd_painter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlgd_painter
// Applies one byte to the group pixel buffer and the colour pair.
// ----------------------------------------------------------------------------
module vlgd_painter (
	input  vlgd_pkg::paint_ctl_t   ctl,
	input  logic [7:0]             in_byte,
	input  vlgd_pkg::group_pix_t   pix_cur,
	input  vlgd_pkg::colour_pair_t col_cur,
	output vlgd_pkg::group_pix_t   pix_nxt,
	output vlgd_pkg::colour_pair_t col_nxt
);
	import vlgd_pkg::*;

	logic [1:0] mod3;
	logic       half;
	logic [2:0] fill_sh;

	always_comb begin
		half = (ctl.data_idx >= 4'd3);
		mod3 = half ? 2'(ctl.data_idx - 4'd3) : ctl.data_idx[1:0];
		case (ctl.code)
			CODE_FILL1: fill_sh = 3'd4;
			CODE_FILL2: fill_sh = 3'd3;
			CODE_FILL4: fill_sh = 3'd2;
			CODE_FILL8: fill_sh = 3'd1;
			default:    fill_sh = 3'd0;
		endcase
	end

	always_comb begin
		pix_nxt = pix_cur;
		col_nxt = col_cur;
		if (ctl.code_byte) begin
			// unknown code: black group
			if (data_bytes_for(in_byte) == 5'd0)
				pix_nxt = '0;
		end else begin
			case (ctl.code)
				CODE_BITMAP3: begin
					if (ctl.data_idx < 4'd2)
						col_nxt[ctl.data_idx[0]] = in_byte;
					else
						for (int i = 0; i < GroupPixels; i++)
							pix_nxt[i] = col_cur[in_byte[3'(7 - i / 2)]];
				end
				CODE_BITMAP6: begin
					if (mod3 != 2'd2)
						col_nxt[mod3[0]] = in_byte;
					else
						for (int i = 0; i < GroupPixels; i++)
							if (1'(i / 8) == half)
								pix_nxt[i] = col_cur[in_byte[3'(7 - i % 8)]];
				end
				CODE_FILL1, CODE_FILL2, CODE_FILL4, CODE_FILL8, CODE_LITERAL: begin
					for (int i = 0; i < GroupPixels; i++)
						if ((4'(i) >> fill_sh) == ctl.data_idx)
							pix_nxt[i] = in_byte;
				end
				default: begin
					pix_nxt = pix_cur;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: tb/video_line_group_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_line_group_decoder_core_tb
// Self-checking bench for the line group decoder. Compressed lines go in one
// byte per item, with random gaps. A line model predicts every decoded
// group, and each group taken from the output channel is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module video_line_group_decoder_core_tb;
	import vlgd_pkg::*;

	localparam int GroupsPerLine = GroupsPerLineDef;
	localparam int RandomBytes   = 1000;  // random test stops once at least this many went in
	localparam int IdleLimit     = 1000;  // cycles with no transfer on either side
	localparam int TailCycles    = 4;     // wait after the last group, with margin

	localparam logic [7:0] KnownCodes [7] = '{
		CODE_FILL1, CODE_FILL2, CODE_BITMAP3, CODE_FILL4,
		CODE_BITMAP6, CODE_FILL8, CODE_LITERAL
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	vlgd_in_if  in_if ();
	vlgd_out_if out_if ();

	video_line_group_decoder_core #(
		.GROUPS_PER_LINE (GroupsPerLine)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_if),
		.out_stream (out_if)
	);

	// ------------------------------------------------------------------------
	// Line model: state of the decoder as seen from its byte stream
	// ------------------------------------------------------------------------
	logic [7:0]  cur_code       = '0;
	int unsigned bytes_in_group = 0;   // 0: next byte is a code byte
	int unsigned group_idx      = 0;
	pixel_t      group_pix [GroupPixels] = '{default: '0};
	pixel_t      pair [2]                = '{default: '0};

	out_item_t expected_groups [$];   // decoded groups not yet seen at the output
	int        errors     = 0;
	int        bytes_sent = 0;
	bit        gaps_on    = 1'b1;     // both sides idle at random when set

	// data bytes after a code byte; unknown codes take none
	function automatic int unsigned data_len(input logic [7:0] code);
		case (code)
			CODE_FILL1:   return 1;
			CODE_FILL2:   return 2;
			CODE_BITMAP3: return 3;
			CODE_FILL4:   return 4;
			CODE_BITMAP6: return 6;
			CODE_FILL8:   return 8;
			CODE_LITERAL: return 16;
			default:      return 0;
		endcase
	endfunction

	// bit 7 of the map first; a set bit picks the second colour of the pair
	function automatic void paint_map(input int unsigned base, input int unsigned rep,
			input logic [7:0] bits);
		pixel_t c;
		for (int k = 0; k < 8; k++) begin
			c = pair[bits[7-k]];
			for (int r = 0; r < rep; r++)
				group_pix[(base + k*rep + r) & 15] = c;
		end
	endfunction

	function automatic void finish_group();
		out_item_t g;
		logic      last;
		last           = (group_idx >= GroupsPerLine - 1);
		g.pixels_0_3   = {group_pix[3],  group_pix[2],  group_pix[1],  group_pix[0]};
		g.pixels_4_7   = {group_pix[7],  group_pix[6],  group_pix[5],  group_pix[4]};
		g.pixels_8_11  = {group_pix[11], group_pix[10], group_pix[9],  group_pix[8]};
		g.pixels_12_15 = {group_pix[15], group_pix[14], group_pix[13], group_pix[12]};
		g.group_index  = 6'(group_idx);
		g.last_group   = last;
		expected_groups.push_back(g);
		// past the last group the counter wraps to a new line
		group_idx = last ? 0 : ((group_idx + 1) & 6'h3F);
	endfunction

	// one accepted byte through the line model
	function automatic void decode_byte(input logic [7:0] b, input logic ls);
		int unsigned d;
		int unsigned run;
		if (ls) begin
			// resync: any partial group is dropped
			bytes_in_group = 0;
			group_idx      = 0;
		end
		if (bytes_in_group == 0) begin
			cur_code = b;
			if (data_len(b) == 0) begin
				// unknown code: a black group at once
				group_pix = '{default: '0};
				finish_group();
			end else begin
				bytes_in_group = 1;
			end
		end else begin
			d = bytes_in_group - 1;
			case (cur_code)
				CODE_BITMAP3: begin
					if (d < 2)
						pair[d] = b;
					else
						paint_map(0, 2, b);
				end
				CODE_BITMAP6: begin
					if ((d % 3) < 2)
						pair[d % 3] = b;
					else
						paint_map((d / 3) * 8, 1, b);
				end
				default: begin
					run = 16 / data_len(cur_code);
					for (int k = 0; k < run; k++)
						group_pix[(d*run + k) & 15] = b;
				end
			endcase
			bytes_in_group++;
			if (bytes_in_group - 1 >= data_len(cur_code)) begin
				bytes_in_group = 0;
				finish_group();
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Byte channel
	// ------------------------------------------------------------------------
	// Called and left at a falling edge. valid stays high on return so that a
	// following byte with no gap goes in back to back.
	task automatic send_byte(input logic [7:0] b, input logic ls);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.item  <= '{in_byte: b, line_start: ls};
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		decode_byte(b, ls);
		bytes_sent++;
		@(negedge clk);
	endtask

	// sender holds off until every predicted group has come out
	task automatic wait_for_groups();
		in_if.valid <= 1'b0;
		@(negedge clk);
		while (expected_groups.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] random_data();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] unknown_code();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (data_len(c) != 0);
		return c;
	endfunction

	// mostly known codes; a raw byte now and then, which may be known too
	function automatic logic [7:0] pick_code();
		if ($urandom_range(0, 9) < 8)
			return KnownCodes[$urandom_range(0, 6)];
		return 8'($urandom_range(0, 255));
	endfunction

	// code byte plus its data bytes; keep >= 0 cuts the group short
	task automatic send_group(input logic [7:0] code, input logic ls, input int keep);
		int n;
		n = data_len(code);
		if (keep >= 0 && keep < n)
			n = keep;
		send_byte(code, ls);
		for (int i = 0; i < n; i++)
			send_byte(random_data(), 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// black groups: zero, all ones and codes next to the known ones
	task automatic test_unknown_codes();
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h11, 1'b0);
	endtask

	task automatic test_fill_codes();
		send_byte(CODE_FILL1, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(CODE_FILL2, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_group(CODE_FILL4, 1'b0, -1);
		send_group(CODE_FILL8, 1'b0, -1);
	endtask

	task automatic test_bitmap_codes();
		send_byte(CODE_BITMAP3, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(CODE_BITMAP6, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h96, 1'b0);
	endtask

	task automatic test_literal();
		send_byte(CODE_LITERAL, 1'b1);
		for (int i = 0; i < 16; i++)
			send_byte(8'(i * 17), 1'b0);   // 00, 11, ... FF
	endtask

	// line start in the middle of a group drops it and restarts at group 0
	task automatic test_line_start_resync();
		send_group(CODE_FILL1, 1'b1, -1);
		send_group(CODE_FILL8, 1'b0, 3);
		send_byte(CODE_FILL1, 1'b1);
		send_byte(8'h5A, 1'b0);
	endtask

	// a full line of black groups, then two more after the wrap to group 0
	task automatic test_line_wrap();
		for (int i = 0; i < GroupsPerLine + 2; i++)
			send_byte(unknown_code(), i == 0);
	endtask

	task automatic test_random_lines();
		int   first;
		logic ls;
		first = bytes_sent;
		while (bytes_sent < first + RandomBytes) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 5) == 0) begin
				// noise: raw bytes, line starts anywhere
				repeat ($urandom_range(5, 30))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end else begin
				// well-formed line; without a line start it follows the wrap
				ls = ($urandom_range(0, 3) != 0);
				for (int g = 0; g < GroupsPerLine; g++) begin
					if ($urandom_range(0, 39) == 0) begin
						// broken group ends the line early
						send_group(pick_code(), ls, $urandom_range(0, 15));
						break;
					end
					send_group(pick_code(), ls, -1);
					ls = 1'b0;
				end
			end
			if ($urandom_range(0, 4) == 0)
				wait_for_groups();
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------------
	// Output side: random stalls and the compare
	// ------------------------------------------------------------------------
	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endfunction

	initial begin : group_compare
		out_item_t want;
		out_item_t got;
		int        hold;
		hold         = 0;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_if.valid && out_if.ready) begin
				got = out_if.item;
				if (expected_groups.size() == 0) begin
					errors++;
					$display("%0t: group expected none, got %h", $time, got);
				end else begin
					want = expected_groups.pop_front();
					check_field("pixels_0_3",   want.pixels_0_3,   got.pixels_0_3);
					check_field("pixels_4_7",   want.pixels_4_7,   got.pixels_4_7);
					check_field("pixels_8_11",  want.pixels_8_11,  got.pixels_8_11);
					check_field("pixels_12_15", want.pixels_12_15, got.pixels_12_15);
					check_field("group_index",  32'(want.group_index),
						32'(got.group_index));
					check_field("last_group",   32'(want.last_group),
						32'(got.last_group));
				end
				// stall drawn per item taken
				hold = gaps_on ? $urandom_range(0, 3) : 0;
			end
			@(negedge clk);
			if (hold > 0) begin
				out_if.ready <= 1'b0;
				hold--;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// ends the run if neither channel moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IdleLimit) begin
			@(posedge clk);
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("video_line_group_decoder_core: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		in_if.valid = 1'b0;
		in_if.item  = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_unknown_codes();
		wait_for_groups();
		test_fill_codes();
		wait_for_groups();
		test_bitmap_codes();
		wait_for_groups();
		test_literal();
		wait_for_groups();
		test_line_start_resync();
		wait_for_groups();
		test_line_wrap();
		wait_for_groups();
		test_random_lines();
		wait_for_groups();

		// any stray group would show up here
		repeat (TailCycles) @(posedge clk);
		if (errors == 0)
			$display("video_line_group_decoder_core: match");
		else
			$display("video_line_group_decoder_core: mismatch");
		$finish;
	end

endmodule
